### hw/rtl/htfl_pkg.sv
// ----------------------------------------------------------------------------
// htfl_pkg
// Shared constants and codes of the handle table free-list allocator.
// ----------------------------------------------------------------------------
package htfl_pkg;

  localparam int TABLE_DEPTH   = 64;
  localparam int ADDRESS_WIDTH = 64;
  localparam int HANDLE_SPAN   = 64;
  localparam int HANDLE_W      = 6;
  localparam int OBJ_ADDR_W    = 64;

  localparam int CAPACITY = (TABLE_DEPTH < HANDLE_SPAN) ? TABLE_DEPTH : HANDLE_SPAN;
  localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int LINK_W   = $clog2(CAPACITY + 1);

  localparam logic [LINK_W-1:0] EMPTY_MARK = LINK_W'(CAPACITY);

  typedef enum logic {
    CMD_ALLOC = 1'b0,
    CMD_FREE  = 1'b1
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_RANGE = 2'd2,
    ST_FREE  = 2'd3
  } status_t;

endpackage

### hw/rtl/handle_table_free_list_allocator.sv
// ----------------------------------------------------------------------------
// handle_table_free_list_allocator
// Fixed table of handle slots with a LIFO free list and a never-used pool.
// ----------------------------------------------------------------------------
// channel   signals                                   handshake
// request   start, command, object_address, handle    taken when start && !busy
// result    done, given_handle, status                one-cycle strobe on done
//
// One request per cycle; the result shows on done in the cycle after acceptance.
// busy is always low: the free-list head and its next two links are held in
// registers, and the link memory is read one pop ahead of use.
// Reset clears the free list, the fresh count and all live bits at once.
// The receiver cannot stall; results are not buffered.
module handle_table_free_list_allocator
  import htfl_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  output logic                  busy,
  input  logic                  command,
  input  logic [OBJ_ADDR_W-1:0] object_address,
  input  logic [HANDLE_W-1:0]   handle,
  output logic                  done,
  output logic [HANDLE_W-1:0]   given_handle,
  output logic [1:0]            status
);

  logic [ADDRESS_WIDTH-1:0] slot_address [CAPACITY];
  logic [LINK_W-1:0]        link_mem     [CAPACITY];

  logic [LINK_W-1:0]   free_head, free_head_next;
  logic [LINK_W-1:0]   head_link, head_link_next;
  logic [LINK_W-1:0]   second_link;
  logic [LINK_W-1:0]   fresh_count, fresh_count_next;
  logic [CAPACITY-1:0] slot_live, slot_live_next;

  logic                accept;
  logic                do_pop, do_fresh, do_push;
  logic [IDX_W-1:0]    alloc_slot;
  logic [IDX_W-1:0]    free_slot;
  status_t             status_next;
  logic [HANDLE_W-1:0] given_next;

  assign busy      = 1'b0;
  assign accept    = start && !busy;
  assign free_slot = handle[IDX_W-1:0];

  always_comb begin
    do_pop           = 1'b0;
    do_fresh         = 1'b0;
    do_push          = 1'b0;
    alloc_slot       = free_head[IDX_W-1:0];
    status_next      = ST_OK;
    given_next       = '0;
    free_head_next   = free_head;
    head_link_next   = head_link;
    fresh_count_next = fresh_count;
    slot_live_next   = slot_live;
    if (command == CMD_ALLOC) begin
      if (free_head != EMPTY_MARK) begin
        do_pop         = 1'b1;
        free_head_next = head_link;
        head_link_next = second_link;
      end else if (fresh_count != LINK_W'(CAPACITY)) begin
        do_fresh         = 1'b1;
        alloc_slot       = fresh_count[IDX_W-1:0];
        fresh_count_next = fresh_count + LINK_W'(1);
      end else begin
        status_next = ST_FULL;
      end
      if (do_pop || do_fresh) begin
        slot_live_next[alloc_slot] = 1'b1;
        given_next                 = HANDLE_W'(alloc_slot);
      end
    end else begin
      if (32'(handle) >= 32'(CAPACITY)) begin
        status_next = ST_RANGE;
      end else if (!slot_live[free_slot]) begin
        status_next = ST_FREE;
      end else begin
        do_push                   = 1'b1;
        free_head_next            = LINK_W'(free_slot);
        head_link_next            = free_head;
        slot_live_next[free_slot] = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      free_head   <= EMPTY_MARK;
      fresh_count <= '0;
      slot_live   <= '0;
      done        <= 1'b0;
    end else begin
      done <= accept;
      if (accept) begin
        free_head    <= free_head_next;
        fresh_count  <= fresh_count_next;
        slot_live    <= slot_live_next;
        given_handle <= given_next;
        status       <= status_next;
      end
    end
  end

  // head_link = link of free_head, second_link = link of head_link
  always_ff @(posedge clk) begin
    if (accept) begin
      head_link <= head_link_next;
      if (do_push) begin
        second_link <= head_link;
      end else if (do_pop) begin
        second_link <= link_mem[second_link[IDX_W-1:0]];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && do_push) begin
      link_mem[free_slot] <= free_head;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && (do_pop || do_fresh)) begin
      slot_address[alloc_slot] <= object_address[ADDRESS_WIDTH-1:0];
    end
  end

  a_fresh_bound: assert property (@(posedge clk) disable iff (rst)
    fresh_count <= LINK_W'(CAPACITY))
    else $error("fresh count beyond capacity");

  a_one_result: assert property (@(posedge clk) disable iff (rst)
    accept |=> done)
    else $error("accepted request gave no result");

  a_alloc_live: assert property (@(posedge clk) disable iff (rst)
    (accept && command == CMD_ALLOC && status_next == ST_OK)
      |=> slot_live[given_handle[IDX_W-1:0]])
    else $error("granted slot not live");

  a_full_pool: assert property (@(posedge clk) disable iff (rst)
    (accept && status_next == ST_FULL)
      |-> (free_head == EMPTY_MARK && fresh_count == LINK_W'(CAPACITY)))
    else $error("table full reported with slots left");

  a_free_clears: assert property (@(posedge clk) disable iff (rst)
    (accept && do_push)
      |=> (!slot_live[$past(free_slot)]
           && free_head == $past(LINK_W'(free_slot))))
    else $error("freed slot not pushed");

endmodule
